/* rtl/tapm_pkg.sv */
`timescale 1ns / 1ps
package tapm_pkg;

    localparam int AngleW = 17;
    localparam int ErrW = 18;
    localparam int GainW = 16;
    localparam int DutyW = 15;
    localparam int MsW = 16;
    localparam int IntegW = 40;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 16;
    localparam int DerivW = 28;
    localparam int SumW = 64;
    localparam int TermLimit = 40;
    localparam logic [DutyW-1:0] CeilingReset = 15'd1400;
    localparam logic [DutyW-1:0] FloorReset = 15'd1000;

    localparam logic [CfgIdxW-1:0] REG_ROLL_KP = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ROLL_KI = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_ROLL_KD = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_PITCH_KP = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_PITCH_KI = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_PITCH_KD = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_CEILING = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_FLOOR = 3'd7;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic axis_sel;
        logic err_prep;
        logic div_start;
        logic div_step;
        logic mul_p;
        logic mul_i;
        logic mul_d;
        logic finish_axis;
        logic mix;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

endpackage

/* rtl/tapm_datapath.sv */
`timescale 1ns / 1ps
module tapm_datapath
    import tapm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic                     cfg_we,
    input  logic [CfgIdxW-1:0]       cfg_index,
    input  logic [CfgDataW-1:0]      cfg_data,
    input  logic signed [AngleW-1:0] measured_roll,
    input  logic signed [AngleW-1:0] measured_pitch,
    input  logic signed [AngleW-1:0] target_roll,
    input  logic signed [AngleW-1:0] target_pitch,
    input  logic [DutyW-1:0]         throttle,
    input  logic [MsW-1:0]           elapsed_ms,
    output logic [DutyW-1:0]         motor_one_duty,
    output logic [DutyW-1:0]         motor_two_duty,
    output logic [DutyW-1:0]         motor_three_duty,
    output logic [DutyW-1:0]         motor_four_duty
);

    logic signed [GainW-1:0] kp_reg [2];
    logic signed [GainW-1:0] ki_reg [2];
    logic signed [GainW-1:0] kd_reg [2];
    logic [DutyW-1:0] ceil_reg, floor_reg;

    logic signed [IntegW-1:0] integ_reg [2];
    logic signed [ErrW-1:0] prev_reg [2];

    logic signed [AngleW-1:0] mr_reg, mp_reg, tr_reg, tp_reg;
    logic [DutyW-1:0] thr_reg;
    logic [MsW-1:0] ms_reg;

    logic signed [ErrW-1:0] err_reg;
    logic signed [SumW-1:0] sum_reg;
    logic signed [7:0] term_reg [2];

    // restoring divider on magnitudes
    logic [DerivW-1:0] quo_reg;
    logic [MsW:0] rem_reg;
    logic neg_reg;
    logic [4:0] cnt_reg;

    logic ax;
    assign ax = cmd.axis_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg[0] <= '0; kp_reg[1] <= '0;
            ki_reg[0] <= '0; ki_reg[1] <= '0;
            kd_reg[0] <= '0; kd_reg[1] <= '0;
            ceil_reg <= CeilingReset;
            floor_reg <= FloorReset;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ROLL_KP: kp_reg[0] <= cfg_data;
                REG_ROLL_KI: ki_reg[0] <= cfg_data;
                REG_ROLL_KD: kd_reg[0] <= cfg_data;
                REG_PITCH_KP: kp_reg[1] <= cfg_data;
                REG_PITCH_KI: ki_reg[1] <= cfg_data;
                REG_PITCH_KD: kd_reg[1] <= cfg_data;
                REG_CEILING: ceil_reg <= cfg_data[DutyW-1:0];
                REG_FLOOR: floor_reg <= cfg_data[DutyW-1:0];
                default: ;
            endcase
        end
    end

    logic signed [ErrW-1:0] err_c;
    assign err_c = ax ? (ErrW'(tp_reg) - ErrW'(mp_reg)) : (ErrW'(tr_reg) - ErrW'(mr_reg));

    logic signed [ErrW:0] diff_c;
    logic signed [ErrW+10:0] dnum_c;
    logic [ErrW+10:0] dmag_c;
    assign diff_c = (ErrW+1)'(err_reg) - (ErrW+1)'(prev_reg[ax]);
    assign dnum_c = (ErrW+11)'(diff_c) * 29'sd1000;
    assign dmag_c = dnum_c[ErrW+10] ? (ErrW+11)'(-dnum_c) : (ErrW+11)'(dnum_c);

    logic signed [IntegW+1:0] inew_c;
    logic signed [ErrW+MsW:0] eprod_c;
    assign eprod_c = (ErrW+MsW+1)'(err_reg) * $signed({1'b0, ms_reg});
    assign inew_c = (IntegW+2)'(integ_reg[ax]) + (IntegW+2)'(eprod_c);

    logic [MsW:0] trial_c;
    assign trial_c = {rem_reg[MsW-1:0], quo_reg[DerivW-1]} - {1'b0, ms_reg};

    logic signed [DerivW:0] deriv_c;
    assign deriv_c = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    logic signed [SumW-1:0] prod_c;
    always_comb begin
        prod_c = '0;
        if (cmd.mul_p) prod_c = SumW'(kp_reg[ax]) * SumW'(err_reg);
        else if (cmd.mul_i) prod_c = SumW'(ki_reg[ax]) * SumW'(integ_reg[ax]);
        else if (cmd.mul_d) prod_c = SumW'(kd_reg[ax]) * SumW'(deriv_c);
    end

    logic signed [SumW-1:0] q_c;
    logic signed [7:0] t_c;
    assign q_c = (sum_reg + (sum_reg[SumW-1] ? SumW'(65535) : SumW'(0))) >>> 16;
    always_comb begin
        if (q_c > SumW'(TermLimit)) t_c = 8'(TermLimit);
        else if (q_c < -SumW'(TermLimit)) t_c = -8'(TermLimit);
        else t_c = q_c[7:0];
    end

    function automatic logic [DutyW-1:0] mixf(input logic [DutyW-1:0] thr,
                                             input logic signed [7:0] t,
                                             input logic [DutyW-1:0] hi,
                                             input logic [DutyW-1:0] lo);
        logic signed [DutyW+1:0] d;
        d = $signed({2'b00, thr}) + (DutyW+2)'(t);
        if (d > $signed({2'b00, hi})) d = $signed({2'b00, hi});
        if (d < $signed({2'b00, lo})) d = $signed({2'b00, lo});
        return d[DutyW-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg[0] <= '0; integ_reg[1] <= '0;
            prev_reg[0] <= '0; prev_reg[1] <= '0;
            cnt_reg <= '0;
        end else begin
            if (cmd.err_prep) begin
                err_reg <= err_c;
            end
            if (cmd.div_start) begin
                quo_reg <= dmag_c[DerivW-1:0];
                rem_reg <= '0;
                neg_reg <= dnum_c[ErrW+10];
                cnt_reg <= 5'(DerivW);
                sum_reg <= '0;
                if (inew_c > (IntegW+2)'(41'sh7F_FFFF_FFFF))
                    integ_reg[ax] <= {1'b0, {(IntegW-1){1'b1}}};
                else if (inew_c < -(IntegW+2)'(42'sh80_0000_0000))
                    integ_reg[ax] <= {1'b1, {(IntegW-1){1'b0}}};
                else
                    integ_reg[ax] <= inew_c[IntegW-1:0];
            end
            if (cmd.div_step && cnt_reg != '0) begin
                if (!trial_c[MsW]) begin
                    rem_reg <= trial_c;
                    quo_reg <= {quo_reg[DerivW-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[MsW-1:0], quo_reg[DerivW-1]};
                    quo_reg <= {quo_reg[DerivW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 5'd1;
            end
            if (cmd.mul_p || cmd.mul_i) sum_reg <= sum_reg + prod_c;
            if (cmd.mul_d && ms_reg != '0) sum_reg <= sum_reg + prod_c;
            if (cmd.finish_axis) begin
                term_reg[ax] <= t_c;
                prev_reg[ax] <= err_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mr_reg <= measured_roll;
            mp_reg <= measured_pitch;
            tr_reg <= target_roll;
            tp_reg <= target_pitch;
            thr_reg <= throttle;
            ms_reg <= elapsed_ms;
        end
        if (cmd.mix) begin
            motor_one_duty <= mixf(thr_reg, -term_reg[0], ceil_reg, floor_reg);
            motor_two_duty <= mixf(thr_reg, term_reg[0], ceil_reg, floor_reg);
            motor_three_duty <= mixf(thr_reg, term_reg[1], ceil_reg, floor_reg);
            motor_four_duty <= mixf(thr_reg, -term_reg[1], ceil_reg, floor_reg);
        end
    end

    assign status.div_done = (cnt_reg == '0);

endmodule

/* rtl/tapm_controller.sv */
`timescale 1ns / 1ps
module tapm_controller
    import tapm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_ERR   = 9'b000000010,
        ST_START = 9'b000000100,
        ST_DIV   = 9'b000001000,
        ST_MP    = 9'b000010000,
        ST_MI    = 9'b000100000,
        ST_MD    = 9'b001000000,
        ST_FIN   = 9'b010000000,
        ST_MIX   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic axis_reg, axis_next;
    logic mv_reg, mv_next;

    logic take;
    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign take = s_valid && s_ready;
    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        axis_next = axis_reg;
        mv_next = mv_reg && !m_ready;
        cmd = '0;
        cmd.axis_sel = axis_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = take;
                if (take) begin
                    state_next = ST_ERR;
                    axis_next = 1'b0;
                end
            end
            ST_ERR: begin
                cmd.err_prep = 1'b1;
                state_next = ST_START;
            end
            ST_START: begin
                cmd.div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) state_next = ST_MP;
            end
            ST_MP: begin
                cmd.mul_p = 1'b1;
                state_next = ST_MI;
            end
            ST_MI: begin
                cmd.mul_i = 1'b1;
                state_next = ST_MD;
            end
            ST_MD: begin
                cmd.mul_d = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.finish_axis = 1'b1;
                if (axis_reg) begin
                    state_next = ST_MIX;
                end else begin
                    axis_next = 1'b1;
                    state_next = ST_ERR;
                end
            end
            ST_MIX: begin
                cmd.mix = 1'b1;
                mv_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg <= axis_next;
            mv_reg <= mv_next;
        end
    end

endmodule

/* rtl/two_axis_pid_motor_mixer.sv */
`timescale 1ns / 1ps
// one update at a time: the next input transfer is accepted only once the block is idle,
// after the 28-step divider has run for each axis
// the result register must be taken before the next input transfer is accepted
// reset: synchronous active-low aresetn clears integrals, previous errors and gains,
// and loads duty ceiling 1400 and floor 1000
module two_axis_pid_motor_mixer
    import tapm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CfgIdxW-1:0]       cfg_index,
    input  logic [CfgDataW-1:0]      cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [AngleW-1:0] s_measured_roll,
    input  logic signed [AngleW-1:0] s_measured_pitch,
    input  logic signed [AngleW-1:0] s_target_roll,
    input  logic signed [AngleW-1:0] s_target_pitch,
    input  logic [DutyW-1:0]         s_throttle,
    input  logic [MsW-1:0]           s_elapsed_ms,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DutyW-1:0]         m_motor_one_duty,
    output logic [DutyW-1:0]         m_motor_two_duty,
    output logic [DutyW-1:0]         m_motor_three_duty,
    output logic [DutyW-1:0]         m_motor_four_duty
);

    dp_cmd_t cmd;
    dp_status_t status;

    tapm_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .status(status), .cmd(cmd)
    );

    tapm_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .status(status),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .measured_roll(s_measured_roll), .measured_pitch(s_measured_pitch),
        .target_roll(s_target_roll), .target_pitch(s_target_pitch),
        .throttle(s_throttle), .elapsed_ms(s_elapsed_ms),
        .motor_one_duty(m_motor_one_duty), .motor_two_duty(m_motor_two_duty),
        .motor_three_duty(m_motor_three_duty), .motor_four_duty(m_motor_four_duty)
    );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import tapm_pkg::*;

    typedef struct packed {
        logic signed [AngleW-1:0] measured_roll;
        logic signed [AngleW-1:0] measured_pitch;
        logic signed [AngleW-1:0] target_roll;
        logic signed [AngleW-1:0] target_pitch;
        logic [DutyW-1:0]         throttle;
        logic [MsW-1:0]           elapsed_ms;
    } update_t;

    typedef struct packed {
        logic [DutyW-1:0] one;
        logic [DutyW-1:0] two;
        logic [DutyW-1:0] three;
        logic [DutyW-1:0] four;
    } duties_t;

    localparam longint IntegHi = (64'sd1 <<< 39) - 1;
    localparam longint IntegLo = -(64'sd1 <<< 39);
    localparam int WatchdogLimit = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [AngleW-1:0] s_measured_roll = '0;
    logic signed [AngleW-1:0] s_measured_pitch = '0;
    logic signed [AngleW-1:0] s_target_roll = '0;
    logic signed [AngleW-1:0] s_target_pitch = '0;
    logic [DutyW-1:0] s_throttle = '0;
    logic [MsW-1:0] s_elapsed_ms = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [DutyW-1:0] m_motor_one_duty, m_motor_two_duty;
    logic [DutyW-1:0] m_motor_three_duty, m_motor_four_duty;

    always #1 aclk = ~aclk;

    two_axis_pid_motor_mixer dut (.*);

    // controller model state
    longint gain_kp[2], gain_ki[2], gain_kd[2];
    longint duty_max, duty_min;
    longint integ[2], prev_err[2];

    update_t pending_updates[$];
    duties_t expected_duties[$];
    int errors = 0;
    bit hold_off = 1'b0;
    int quiet_cycles = 0;

    function automatic longint lim(longint v, longint lo, longint hi);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v;
    endfunction

    function automatic longint axis_correction(int a, longint err, longint ms);
        longint d;
        longint sum;
        d = 0;
        integ[a] = lim(integ[a] + err * ms, IntegLo, IntegHi);
        if (ms != 0) d = ((err - prev_err[a]) * 1000) / ms;
        prev_err[a] = err;
        sum = gain_kp[a] * err + gain_ki[a] * integ[a] + gain_kd[a] * d;
        return lim(sum / 65536, -TermLimit, TermLimit);
    endfunction

    function automatic logic [DutyW-1:0] duty_mix(longint thr, longint term);
        longint v;
        v = thr + term;
        if (v > duty_max) v = duty_max;
        if (v < duty_min) v = duty_min;
        return v[DutyW-1:0];
    endfunction

    function automatic duties_t predict_duties(update_t u);
        longint r, p, thr;
        duties_t d;
        r = axis_correction(0, longint'(u.target_roll) - longint'(u.measured_roll),
                            longint'(u.elapsed_ms));
        p = axis_correction(1, longint'(u.target_pitch) - longint'(u.measured_pitch),
                            longint'(u.elapsed_ms));
        thr = longint'(u.throttle);
        d.one = duty_mix(thr, -r);
        d.two = duty_mix(thr, r);
        d.three = duty_mix(thr, p);
        d.four = duty_mix(thr, -p);
        return d;
    endfunction

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ROLL_KP: gain_kp[0] = longint'($signed(val));
            REG_ROLL_KI: gain_ki[0] = longint'($signed(val));
            REG_ROLL_KD: gain_kd[0] = longint'($signed(val));
            REG_PITCH_KP: gain_kp[1] = longint'($signed(val));
            REG_PITCH_KI: gain_ki[1] = longint'($signed(val));
            REG_PITCH_KD: gain_kd[1] = longint'($signed(val));
            REG_CEILING: duty_max = longint'(val[DutyW-1:0]);
            REG_FLOOR: duty_min = longint'(val[DutyW-1:0]);
            default: ;
        endcase
    endtask

    task automatic write_all(logic [CfgDataW-1:0] kp0, logic [CfgDataW-1:0] ki0,
                             logic [CfgDataW-1:0] kd0, logic [CfgDataW-1:0] kp1,
                             logic [CfgDataW-1:0] ki1, logic [CfgDataW-1:0] kd1,
                             logic [CfgDataW-1:0] ceil, logic [CfgDataW-1:0] flr);
        write_reg(REG_ROLL_KP, kp0);
        write_reg(REG_ROLL_KI, ki0);
        write_reg(REG_ROLL_KD, kd0);
        write_reg(REG_PITCH_KP, kp1);
        write_reg(REG_PITCH_KI, ki1);
        write_reg(REG_PITCH_KD, kd1);
        write_reg(REG_CEILING, ceil);
        write_reg(REG_FLOOR, flr);
    endtask

    function automatic logic signed [AngleW-1:0] rand_angle(int mode);
        if (mode == 0) return AngleW'($signed($urandom_range(92160)) - 46080);
        return AngleW'($signed($urandom_range(2048)) - 1024);
    endfunction

    function automatic update_t rand_update();
        update_t u;
        int mode;
        mode = ($urandom_range(3) == 0) ? 0 : 1;
        u.measured_roll = rand_angle(mode);
        u.measured_pitch = rand_angle(mode);
        u.target_roll = rand_angle(mode);
        u.target_pitch = rand_angle(mode);
        u.throttle = ($urandom_range(3) == 0) ? DutyW'($urandom_range(20000))
                                              : DutyW'($urandom_range(900, 1500));
        case ($urandom_range(4))
            0: u.elapsed_ms = '0;
            1: u.elapsed_ms = MsW'($urandom_range(65535));
            default: u.elapsed_ms = MsW'($urandom_range(1, 20));
        endcase
        return u;
    endfunction

    function automatic update_t make_update(int mr, int mp, int tr, int tp, int thr, int ms);
        update_t u;
        u.measured_roll = AngleW'(mr);
        u.measured_pitch = AngleW'(mp);
        u.target_roll = AngleW'(tr);
        u.target_pitch = AngleW'(tp);
        u.throttle = DutyW'(thr);
        u.elapsed_ms = MsW'(ms);
        return u;
    endfunction

    task automatic drain();
        while (pending_updates.size() != 0 || s_valid || expected_duties.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic run_random(int count);
        repeat (count) pending_updates.push_back(rand_update());
        drain();
    endtask

    // driver
    int send_wait = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_duties.push_back(predict_duties({s_measured_roll,
                    s_measured_pitch, s_target_roll, s_target_pitch,
                    s_throttle, s_elapsed_ms}));
            end
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                    s_valid <= 1'b0;
                end else if (pending_updates.size() != 0) begin
                    update_t u;
                    u = pending_updates.pop_front();
                    s_measured_roll <= u.measured_roll;
                    s_measured_pitch <= u.measured_pitch;
                    s_target_roll <= u.target_roll;
                    s_target_pitch <= u.target_pitch;
                    s_throttle <= u.throttle;
                    s_elapsed_ms <= u.elapsed_ms;
                    s_valid <= 1'b1;
                    send_wait <= ($urandom_range(2) == 0) ? 0 : $urandom_range(12);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int recv_wait = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_duties.size() == 0) begin
                    $error("unexpected transfer");
                    errors++;
                end else begin
                    duties_t e;
                    e = expected_duties.pop_front();
                    if (m_motor_one_duty !== e.one) begin
                        $error("motor_one_duty exp %0d got %0d", e.one, m_motor_one_duty);
                        errors++;
                    end
                    if (m_motor_two_duty !== e.two) begin
                        $error("motor_two_duty exp %0d got %0d", e.two, m_motor_two_duty);
                        errors++;
                    end
                    if (m_motor_three_duty !== e.three) begin
                        $error("motor_three_duty exp %0d got %0d", e.three,
                               m_motor_three_duty);
                        errors++;
                    end
                    if (m_motor_four_duty !== e.four) begin
                        $error("motor_four_duty exp %0d got %0d", e.four, m_motor_four_duty);
                        errors++;
                    end
                end
                recv_wait <= ($urandom_range(2) == 0) ? 0 : $urandom_range(12);
                m_ready <= 1'b0;
            end else if (hold_off) begin
                m_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("two_axis_pid_motor_mixer: mismatch");
            $finish;
        end
    end

    initial begin
        gain_kp = '{0, 0};
        gain_ki = '{0, 0};
        gain_kd = '{0, 0};
        integ = '{0, 0};
        prev_err = '{0, 0};
        duty_max = 1400;
        duty_min = 1000;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset gains: duties are throttle clamped to reset limits
        pending_updates.push_back(make_update(0, 0, 0, 0, 1200, 5));
        pending_updates.push_back(make_update(0, 0, 0, 0, 0, 0));
        pending_updates.push_back(make_update(0, 0, 0, 0, 20000, 65535));
        drain();

        write_all(16'sd256, 16'sd2, 16'sd1, 16'sd256, 16'sd2, 16'sd1, 16'd2000, 16'd500);
        pending_updates.push_back(make_update(-46080, 46080, 46080, -46080, 1200, 0));
        pending_updates.push_back(make_update(46080, -46080, -46080, 46080, 1200, 65535));
        pending_updates.push_back(make_update(0, 0, 0, 0, 1200, 1));
        pending_updates.push_back(make_update(100, -100, 200, -300, 0, 10));
        pending_updates.push_back(make_update(0, 0, 5, -5, 20000, 3));
        drain();

        // extreme gains, floor above ceiling
        write_all(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff,
                  16'd20000, 16'd0);
        repeat (6) pending_updates.push_back(make_update(-46080, 46080, 46080, -46080,
                                                         10000, 65535));
        repeat (4) pending_updates.push_back(make_update(46080, -46080, -46080, 46080,
                                                         30, 65535));
        pending_updates.push_back(make_update(0, 0, 0, 0, 32767, 0));
        drain();
        write_all(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd1000, 16'd1400);
        pending_updates.push_back(make_update(0, 0, 100, 100, 1200, 4));
        drain();

        // long receiver stall while the sender keeps offering
        write_all(16'sd40, 16'sd1, 16'sd20, -16'sd40, 16'sd3, -16'sd10, 16'd1600, 16'd900);
        hold_off = 1'b1;
        repeat (8) pending_updates.push_back(rand_update());
        repeat (400) @(posedge aclk);
        hold_off = 1'b0;
        drain();

        repeat (8) begin
            write_all(CfgDataW'($urandom), CfgDataW'($urandom_range(64)),
                      CfgDataW'($urandom), CfgDataW'($urandom),
                      CfgDataW'($urandom_range(64)), CfgDataW'($urandom),
                      CfgDataW'($urandom_range(1200, 20000)),
                      CfgDataW'($urandom_range(0, 1300)));
            run_random(25);
            write_all(CfgDataW'($urandom_range(512)), CfgDataW'($urandom_range(8)),
                      CfgDataW'($urandom_range(64)), CfgDataW'(-$urandom_range(512)),
                      CfgDataW'($urandom_range(8)), CfgDataW'(-$urandom_range(64)),
                      CfgDataW'($urandom_range(1300, 1800)),
                      CfgDataW'($urandom_range(800, 1100)));
            run_random(25);
        end

        if (errors == 0)
            $display("two_axis_pid_motor_mixer: match");
        else
            $display("two_axis_pid_motor_mixer: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tapm_pkg.sv
rtl/tapm_datapath.sv
rtl/tapm_controller.sv
rtl/two_axis_pid_motor_mixer.sv
verif/testbench.sv
